FILE: rtl/core/ipt_pkg.sv
// ----------------------------------------------------------------------------
// ipt_pkg: shared definitions for the indexed priority table
// Sizes, operation and status codes, and the control words that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package ipt_pkg;

    // Table geometry and field widths.
    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int ID_W     = 16;
    localparam int CNT_W    = ID_W + 1;
    localparam int PRI_W    = 16;
    localparam int PAY_W    = 32;
    localparam int OP_W     = 3;
    localparam int ST_W     = 3;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_ADD      = 3'd0;
    localparam logic [OP_W-1:0] OP_PROMOTE  = 3'd1;
    localparam logic [OP_W-1:0] OP_IS_VALID = 3'd2;
    localparam logic [OP_W-1:0] OP_GET      = 3'd3;
    localparam logic [OP_W-1:0] OP_GET_MAX  = 3'd4;
    localparam logic [OP_W-1:0] OP_POP_MAX  = 3'd5;

    // Status codes.
    localparam logic [ST_W-1:0] ST_OK        = 3'd0;
    localparam logic [ST_W-1:0] ST_FULL      = 3'd1;
    localparam logic [ST_W-1:0] ST_UNKNOWN   = 3'd2;
    localparam logic [ST_W-1:0] ST_EMPTY     = 3'd3;
    localparam logic [ST_W-1:0] ST_EXHAUSTED = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // capture the command word and clear the scan state
        logic scan;    // examine one slot
        logic commit;  // update the table and register the result
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_last;  // the slot being examined is the last one
    } t_stat;

endpackage

FILE: rtl/core/ipt_ctrl.sv
// ----------------------------------------------------------------------------
// ipt_ctrl: sequencer for the indexed priority table
// Walks each command through a load, a scan of every slot and a commit,
// and raises the result strobe in the cycle after the commit.
// ----------------------------------------------------------------------------
module ipt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    output logic          o_done,
    output ipt_pkg::t_cmd o_cmd,
    input  ipt_pkg::t_stat i_stat
);
    import ipt_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT
    } t_state;

    t_state r_state, n_state;
    logic   r_done;

    // Next state and commands.
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and the registered result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_COMMIT);
        end
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;

endmodule

FILE: rtl/core/ipt_dpath.sv
// ----------------------------------------------------------------------------
// ipt_dpath: slot storage and scan datapath
// Holds the slot table and the id counter, examines one slot per scan
// cycle to find the id match, the lowest free slot and the maximum entry,
// then applies the operation and registers the result word.
// ----------------------------------------------------------------------------
module ipt_dpath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ipt_pkg::t_cmd               i_cmd,
    output ipt_pkg::t_stat              o_stat,
    input  logic [ipt_pkg::OP_W-1:0]    i_operation,
    input  logic [ipt_pkg::ID_W-1:0]    i_entry_id,
    input  logic [ipt_pkg::PAY_W-1:0]   i_payload_in,
    output logic [ipt_pkg::ST_W-1:0]    o_status,
    output logic [ipt_pkg::ID_W-1:0]    o_id_out,
    output logic [ipt_pkg::PAY_W-1:0]   o_payload_out,
    output logic [ipt_pkg::PRI_W-1:0]   o_priority_out,
    output logic                        o_present
);
    import ipt_pkg::*;

    // Slot table.
    logic [CAPACITY-1:0] r_used;
    logic [ID_W-1:0]     r_slot_id  [CAPACITY];
    logic [PRI_W-1:0]    r_slot_pri [CAPACITY];
    logic [PAY_W-1:0]    r_slot_pay [CAPACITY];
    logic [CNT_W-1:0]    r_cnt;

    // Captured command word.
    logic [OP_W-1:0]     r_op;
    logic [ID_W-1:0]     r_eid;
    logic [PAY_W-1:0]    r_pin;

    // Scan state.
    logic [IDX_W-1:0]    r_idx;
    logic                r_hit;
    logic [IDX_W-1:0]    r_hit_idx;
    logic [PRI_W-1:0]    r_hit_pri;
    logic [PAY_W-1:0]    r_hit_pay;
    logic                r_free_ok;
    logic [IDX_W-1:0]    r_free_idx;
    logic                r_best_ok;
    logic [IDX_W-1:0]    r_best_idx;
    logic [PRI_W-1:0]    r_best_pri;
    logic [ID_W-1:0]     r_best_id;
    logic [PAY_W-1:0]    r_best_pay;

    // Result registers.
    logic [ST_W-1:0]     r_status;
    logic [ID_W-1:0]     r_id_out;
    logic [PAY_W-1:0]    r_pay_out;
    logic [PRI_W-1:0]    r_pri_out;
    logic                r_present;

    // Current slot under the scan pointer.
    logic                cur_used;
    logic [ID_W-1:0]     cur_id;
    logic [PRI_W-1:0]    cur_pri;
    logic [PAY_W-1:0]    cur_pay;
    logic                cur_better;

    // Commit decisions.
    logic [ST_W-1:0]     n_status;
    logic [ID_W-1:0]     n_id_out;
    logic [PAY_W-1:0]    n_pay_out;
    logic [PRI_W-1:0]    n_pri_out;
    logic                n_present;
    logic                wr_add;
    logic                wr_pro;
    logic                wr_pop;
    logic [PRI_W-1:0]    pro_pri;

    assign cur_used = r_used[r_idx];
    assign cur_id   = r_slot_id[r_idx];
    assign cur_pri  = r_slot_pri[r_idx];
    assign cur_pay  = r_slot_pay[r_idx];

    // A used slot wins over the best so far on higher priority, then larger id.
    assign cur_better = cur_used && (!r_best_ok || (cur_pri > r_best_pri) ||
                        ((cur_pri == r_best_pri) && (cur_id > r_best_id)));

    assign o_stat.scan_last = (r_idx == IDX_W'(CAPACITY - 1));

    // Promote saturates at the top of the priority range.
    assign pro_pri = (r_hit_pri == {PRI_W{1'b1}}) ? r_hit_pri : r_hit_pri + 1'b1;

    // Result word and table updates for the operation.
    always_comb begin
        n_status  = ST_OK;
        n_id_out  = '0;
        n_pay_out = '0;
        n_pri_out = '0;
        n_present = 1'b0;
        wr_add    = 1'b0;
        wr_pro    = 1'b0;
        wr_pop    = 1'b0;
        case (r_op)
            OP_ADD: begin
                if (r_cnt[ID_W]) begin
                    n_status = ST_EXHAUSTED;
                end else if (!r_free_ok) begin
                    n_status = ST_FULL;
                end else begin
                    n_id_out = r_cnt[ID_W-1:0];
                    wr_add   = 1'b1;
                end
            end
            OP_PROMOTE: begin
                n_id_out = r_eid;
                if (!r_hit) begin
                    n_status = ST_UNKNOWN;
                end else begin
                    n_pri_out = pro_pri;
                    wr_pro    = 1'b1;
                end
            end
            OP_IS_VALID: begin
                n_id_out  = r_eid;
                n_present = r_hit;
            end
            OP_GET: begin
                n_id_out = r_eid;
                if (!r_hit) begin
                    n_status = ST_UNKNOWN;
                end else begin
                    n_pay_out = r_hit_pay;
                    n_pri_out = r_hit_pri;
                end
            end
            OP_GET_MAX, OP_POP_MAX: begin
                if (!r_best_ok) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_id_out  = r_best_id;
                    n_pay_out = r_best_pay;
                    n_pri_out = r_best_pri;
                    wr_pop    = (r_op == OP_POP_MAX);
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    // Control state: used bits, id counter and scan flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used    <= '0;
            r_cnt     <= '0;
            r_idx     <= '0;
            r_hit     <= 1'b0;
            r_free_ok <= 1'b0;
            r_best_ok <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_idx     <= '0;
                r_hit     <= 1'b0;
                r_free_ok <= 1'b0;
                r_best_ok <= 1'b0;
            end
            if (i_cmd.scan) begin
                r_idx <= r_idx + 1'b1;
                if (cur_used && (cur_id == r_eid)) begin
                    r_hit <= 1'b1;
                end
                if (!cur_used) begin
                    r_free_ok <= 1'b1;
                end
                if (cur_better) begin
                    r_best_ok <= 1'b1;
                end
            end
            if (i_cmd.commit) begin
                if (wr_add) begin
                    r_used[r_free_idx] <= 1'b1;
                    r_cnt              <= r_cnt + 1'b1;
                end
                if (wr_pop) begin
                    r_used[r_best_idx] <= 1'b0;
                end
            end
        end
    end

    // Payload state: slot contents, captured word, scan candidates, result.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_operation;
            r_eid <= i_entry_id;
            r_pin <= i_payload_in;
        end
        if (i_cmd.scan) begin
            if (cur_used && (cur_id == r_eid)) begin
                r_hit_idx <= r_idx;
                r_hit_pri <= cur_pri;
                r_hit_pay <= cur_pay;
            end
            if (!cur_used && !r_free_ok) begin
                r_free_idx <= r_idx;
            end
            if (cur_better) begin
                r_best_idx <= r_idx;
                r_best_pri <= cur_pri;
                r_best_id  <= cur_id;
                r_best_pay <= cur_pay;
            end
        end
        if (i_cmd.commit) begin
            if (wr_add) begin
                r_slot_id[r_free_idx]  <= r_cnt[ID_W-1:0];
                r_slot_pri[r_free_idx] <= '0;
                r_slot_pay[r_free_idx] <= r_pin;
            end
            if (wr_pro) begin
                r_slot_pri[r_hit_idx] <= pro_pri;
            end
            r_status  <= n_status;
            r_id_out  <= n_id_out;
            r_pay_out <= n_pay_out;
            r_pri_out <= n_pri_out;
            r_present <= n_present;
        end
    end

    assign o_status       = r_status;
    assign o_id_out       = r_id_out;
    assign o_payload_out  = r_pay_out;
    assign o_priority_out = r_pri_out;
    assign o_present      = r_present;

endmodule

FILE: rtl/core/indexed_priority_table.sv
// ----------------------------------------------------------------------------
// indexed_priority_table: id-indexed priority table
// Stores entries under never-reused ids and serves add, promote, lookup,
// get-max and pop-max commands over a table of CAPACITY slots.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake            Fields
//   -------   ------------------   ---------------------------------------------
//   command   start, busy          i_operation, i_entry_id, i_payload_in
//   result    o_done (one cycle)   o_status, o_id_out, o_payload_out,
//                                  o_priority_out, o_present
//
// A word is taken at the edge where start is high and busy is low. Every
// command scans all slots, one slot per cycle, then a commit step updates
// the table and registers the result, and o_done is registered from the
// commit state; busy drops in the cycle o_done is shown, so the next word
// can be taken at the edge that takes the result, and no word is taken
// while a command is in progress. The slot scan sets the rate. Reset clears
// the used bits and the id counter at once. The receiver cannot stall: each
// result is shown for exactly one cycle.
//
module indexed_priority_table (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [ipt_pkg::OP_W-1:0]    i_operation,
    input  logic [ipt_pkg::ID_W-1:0]    i_entry_id,
    input  logic [ipt_pkg::PAY_W-1:0]   i_payload_in,
    output logic                        o_done,
    output logic [ipt_pkg::ST_W-1:0]    o_status,
    output logic [ipt_pkg::ID_W-1:0]    o_id_out,
    output logic [ipt_pkg::PAY_W-1:0]   o_payload_out,
    output logic [ipt_pkg::PRI_W-1:0]   o_priority_out,
    output logic                        o_present
);
    import ipt_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // Sequencer.
    ipt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_done  (o_done),
        .o_cmd   (cmd),
        .i_stat  (stat)
    );

    // Table and scan datapath.
    ipt_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_operation    (i_operation),
        .i_entry_id     (i_entry_id),
        .i_payload_in   (i_payload_in),
        .o_status       (o_status),
        .o_id_out       (o_id_out),
        .o_payload_out  (o_payload_out),
        .o_priority_out (o_priority_out),
        .o_present      (o_present)
    );

endmodule
